>>> rtl/tbs_pkg.sv
package tbs_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TOL_BITS       = 31;
  localparam int TUSER_BITS     = 3;
  localparam int NUM_VERT       = 4;
  localparam int NUM_AXIS       = 3;
  localparam int LAT_COF        = 6;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } tbs_axis_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ROW_X,
    SEQ_ROW_Y,
    SEQ_ROW_Z
  } tbs_seq_state_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sing;
  } tbs_lane_ctl_t;

  function automatic int tbs_div_lat(input int coord_bits);
    return coord_bits + 3;
  endfunction

endpackage

>>> rtl/tbs_seq.sv
module tbs_seq #(
  parameter int COORD_BITS = tbs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [12*COORD_BITS-1:0]            in_vtx,
  output logic                                in_ready,
  output logic                                iss_valid,
  output tbs_pkg::tbs_axis_t                  iss_axis,
  output logic                                iss_last,
  output logic [3*(COORD_BITS+1)-1:0]         iss_rr,
  output logic [3*(COORD_BITS+1)-1:0]         iss_ra,
  output logic [3*(COORD_BITS+1)-1:0]         iss_rb,
  output logic [4*COORD_BITS-1:0]             iss_crd
);
  import tbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 1;

  tbs_seq_state_t state_r, state_nxt;
  logic           in_acc;
  logic           issue;
  tbs_axis_t      axis_cur;

  logic signed [CB-1:0] vtx_r [NUM_VERT][NUM_AXIS];
  logic signed [EW-1:0] m_r   [NUM_AXIS][NUM_AXIS];

  logic                     iss_valid_r;
  tbs_axis_t                iss_axis_r;
  logic                     iss_last_r;
  logic [3*EW-1:0]          iss_rr_r, iss_ra_r, iss_rb_r;
  logic [4*CB-1:0]          iss_crd_r;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    case (state_r)
      SEQ_IDLE:  state_nxt = in_acc ? SEQ_ROW_X : SEQ_IDLE;
      SEQ_ROW_X: state_nxt = en ? SEQ_ROW_Y : SEQ_ROW_X;
      SEQ_ROW_Y: state_nxt = en ? SEQ_ROW_Z : SEQ_ROW_Y;
      SEQ_ROW_Z: state_nxt = in_acc ? SEQ_ROW_X : (en ? SEQ_IDLE : SEQ_ROW_Z);
      default:   state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = en && ((state_r == SEQ_IDLE) || (state_r == SEQ_ROW_Z));
    issue    = en && (state_r != SEQ_IDLE);
    case (state_r)
      SEQ_ROW_X: axis_cur = AXIS_X;
      SEQ_ROW_Y: axis_cur = AXIS_Y;
      SEQ_ROW_Z: axis_cur = AXIS_Z;
      default:   axis_cur = AXIS_X;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      iss_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (en) begin
        iss_valid_r <= (state_r != SEQ_IDLE);
      end
    end
  end

  // Rows and axes rotate after each issue, so the current row always sits in slot 0.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        for (int a = 0; a < NUM_AXIS; a++) begin
          vtx_r[k][a] <= in_vtx[(k*NUM_AXIS+a)*CB +: CB];
        end
      end
      for (int j = 0; j < NUM_AXIS; j++) begin
        for (int a = 0; a < NUM_AXIS; a++) begin
          m_r[j][a] <= $signed({in_vtx[((j+1)*NUM_AXIS+a)*CB+CB-1],
                                in_vtx[((j+1)*NUM_AXIS+a)*CB +: CB]})
                     - $signed({in_vtx[a*CB+CB-1], in_vtx[a*CB +: CB]});
        end
      end
    end else if (issue) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        for (int a = 0; a < NUM_AXIS; a++) begin
          vtx_r[k][a] <= vtx_r[k][(a+1)%NUM_AXIS];
        end
      end
      for (int j = 0; j < NUM_AXIS; j++) begin
        for (int a = 0; a < NUM_AXIS; a++) begin
          m_r[j][a] <= m_r[(j+1)%NUM_AXIS][a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iss_axis_r <= axis_cur;
      iss_last_r <= (state_r == SEQ_ROW_Z);
      for (int c = 0; c < NUM_AXIS; c++) begin
        iss_rr_r[c*EW +: EW] <= m_r[0][c];
        iss_ra_r[c*EW +: EW] <= m_r[1][c];
        iss_rb_r[c*EW +: EW] <= m_r[2][c];
      end
      for (int k = 0; k < NUM_VERT; k++) begin
        iss_crd_r[k*CB +: CB] <= vtx_r[k][0];
      end
    end
  end

  assign iss_valid = iss_valid_r;
  assign iss_axis  = iss_axis_r;
  assign iss_last  = iss_last_r;
  assign iss_rr    = iss_rr_r;
  assign iss_ra    = iss_ra_r;
  assign iss_rb    = iss_rb_r;
  assign iss_crd   = iss_crd_r;

endmodule

>>> rtl/tbs_cof.sv
module tbs_cof #(
  parameter int COORD_BITS = tbs_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      iss_valid,
  input  logic [3*(COORD_BITS+1)-1:0]               iss_rr,
  input  logic [3*(COORD_BITS+1)-1:0]               iss_ra,
  input  logic [3*(COORD_BITS+1)-1:0]               iss_rb,
  output tbs_pkg::tbs_lane_ctl_t [2:0]              lane_ctl,
  output logic [3*(2*COORD_BITS+3)-1:0]             cof_mag,
  output logic [3*COORD_BITS+6-1:0]                 det_mag
);
  import tbs_pkg::*;

  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int XW  = EW + CW;
  localparam int DW  = XW + 2;
  localparam int LOW = CW / 2;
  localparam int PLW = EW + LOW + 1;
  localparam int PHW = EW + CW - LOW;

  logic signed [EW-1:0]  rr_s [NUM_AXIS];
  logic signed [EW-1:0]  ra_s [NUM_AXIS];
  logic signed [EW-1:0]  rb_s [NUM_AXIS];

  logic [LAT_COF-1:0]    vld_r;

  logic signed [PW-1:0]  p1_r   [NUM_AXIS];
  logic signed [PW-1:0]  q1_r   [NUM_AXIS];
  logic signed [EW-1:0]  rr1_r  [NUM_AXIS];
  logic signed [CW-1:0]  cof2_r [NUM_AXIS];
  logic signed [EW-1:0]  rr2_r  [NUM_AXIS];
  logic signed [PLW-1:0] plo3_r [NUM_AXIS];
  logic signed [PHW-1:0] phi3_r [NUM_AXIS];
  logic signed [CW-1:0]  cof3_r [NUM_AXIS];
  logic signed [XW-1:0]  prod4_r[NUM_AXIS];
  logic signed [CW-1:0]  cof4_r [NUM_AXIS];
  logic signed [DW-1:0]  det5_r;
  logic signed [CW-1:0]  cof5_r [NUM_AXIS];
  logic [CW-1:0]         cmag6_r[NUM_AXIS];
  logic [NUM_AXIS-1:0]   neg6_r;
  logic [DW-1:0]         dmag6_r;
  logic                  sing6_r;

  always_comb begin
    for (int c = 0; c < NUM_AXIS; c++) begin
      rr_s[c] = iss_rr[c*EW +: EW];
      ra_s[c] = iss_ra[c*EW +: EW];
      rb_s[c] = iss_rb[c*EW +: EW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT_COF-2:0], iss_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_AXIS; c++) begin
        p1_r[c]  <= ra_s[(c+1)%NUM_AXIS] * rb_s[(c+2)%NUM_AXIS];
        q1_r[c]  <= ra_s[(c+2)%NUM_AXIS] * rb_s[(c+1)%NUM_AXIS];
        rr1_r[c] <= rr_s[c];

        cof2_r[c] <= $signed({p1_r[c][PW-1], p1_r[c]}) - $signed({q1_r[c][PW-1], q1_r[c]});
        rr2_r[c]  <= rr1_r[c];

        plo3_r[c] <= rr2_r[c] * $signed({1'b0, cof2_r[c][LOW-1:0]});
        phi3_r[c] <= rr2_r[c] * $signed(cof2_r[c][CW-1:LOW]);
        cof3_r[c] <= cof2_r[c];

        prod4_r[c] <= $signed({phi3_r[c], {LOW{1'b0}}})
                    + $signed({{(XW-PLW){plo3_r[c][PLW-1]}}, plo3_r[c]});
        cof4_r[c]  <= cof3_r[c];

        cof5_r[c] <= cof4_r[c];
      end
      det5_r <= $signed({{2{prod4_r[0][XW-1]}}, prod4_r[0]})
              + $signed({{2{prod4_r[1][XW-1]}}, prod4_r[1]})
              + $signed({{2{prod4_r[2][XW-1]}}, prod4_r[2]});

      for (int c = 0; c < NUM_AXIS; c++) begin
        cmag6_r[c] <= cof5_r[c][CW-1] ? (~cof5_r[c] + 1'b1) : cof5_r[c];
        neg6_r[c]  <= cof5_r[c][CW-1] ^ det5_r[DW-1];
      end
      dmag6_r <= det5_r[DW-1] ? (~det5_r + 1'b1) : det5_r;
      sing6_r <= (det5_r == '0);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_AXIS; c++) begin
      lane_ctl[c].valid      = vld_r[LAT_COF-1];
      lane_ctl[c].neg        = neg6_r[c];
      lane_ctl[c].sing       = sing6_r;
      cof_mag[c*CW +: CW]    = cmag6_r[c];
    end
    det_mag = dmag6_r;
  end

endmodule

>>> rtl/tbs_div.sv
module tbs_div #(
  parameter int COORD_BITS = tbs_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tbs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tbs_pkg::tbs_lane_ctl_t        ctl_in,
  input  logic [2*COORD_BITS+2:0]       cof_mag,
  input  logic [3*COORD_BITS+5:0]       det_mag,
  output tbs_pkg::tbs_lane_ctl_t        ctl_out,
  output logic [COORD_BITS-1:0]         quot
);
  import tbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 1;
  localparam int CW = 2 * EW + 1;
  localparam int DW = EW + CW + 2;
  localparam int QB = CB + 1;
  localparam int TW = CW + 2 * FRAC_BITS + 1;
  localparam int RW = (TW > DW + QB) ? TW : DW + QB;

  localparam logic [QB-1:0] POS_LIM = {2'b00, {(CB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_LIM = {2'b01, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] SAT_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] SAT_MIN = {1'b1, {(CB-1){1'b0}}};

  logic [RW-1:0]   rem_r [QB+1];
  logic [DW-1:0]   den_r [QB+1];
  logic [QB-1:0]   q_r   [QB+1];
  logic            ovf_r [QB+1];
  tbs_lane_ctl_t   ctl_r [QB+1];

  logic [RW-1:0]   t_w;
  logic [RW-1:0]   dlim_w;
  logic [QB:0]     qp1_w;
  logic [QB-1:0]   qr_w;
  logic            sat_pos, sat_neg;
  logic [CB-1:0]   res_w;
  logic [CB-1:0]   quot_r;
  tbs_lane_ctl_t   ctl_out_r;

  // Twice the scaled quotient is formed so the last bit gives round to nearest.
  assign t_w    = {{(RW-CW){1'b0}}, cof_mag} << (2 * FRAC_BITS + 1);
  assign dlim_w = {{(RW-DW){1'b0}}, det_mag} << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0].valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]      <= t_w;
      den_r[0]      <= det_mag;
      q_r[0]        <= '0;
      ovf_r[0]      <= (t_w >= dlim_w);
      ctl_r[0].neg  <= ctl_in.neg;
      ctl_r[0].sing <= ctl_in.sing;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int BI = QB - 1 - k;
    logic [RW-1:0] ds_w;
    logic          ge_w;

    assign ds_w = {{(RW-DW){1'b0}}, den_r[k]} << BI;
    assign ge_w = (rem_r[k] >= ds_w);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1].valid <= 1'b0;
      end else if (en) begin
        ctl_r[k+1].valid <= ctl_r[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]      <= ge_w ? (rem_r[k] - ds_w) : rem_r[k];
        den_r[k+1]      <= den_r[k];
        q_r[k+1]        <= q_r[k] | ({{(QB-1){1'b0}}, ge_w} << BI);
        ovf_r[k+1]      <= ovf_r[k];
        ctl_r[k+1].neg  <= ctl_r[k].neg;
        ctl_r[k+1].sing <= ctl_r[k].sing;
      end
    end
  end

  always_comb begin
    qp1_w   = {1'b0, q_r[QB]} + 1'b1;
    qr_w    = qp1_w[QB:1];
    sat_pos = ovf_r[QB] || (qr_w > POS_LIM);
    sat_neg = ovf_r[QB] || (qr_w > NEG_LIM);
    if (ctl_r[QB].sing) begin
      res_w = '0;
    end else if (ctl_r[QB].neg) begin
      res_w = sat_neg ? SAT_MIN : (~qr_w[CB-1:0] + 1'b1);
    end else begin
      res_w = sat_pos ? SAT_MAX : qr_w[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r.valid <= 1'b0;
    end else if (en) begin
      ctl_out_r.valid <= ctl_r[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r         <= res_w;
      ctl_out_r.neg  <= ctl_r[QB].neg;
      ctl_out_r.sing <= ctl_r[QB].sing;
    end
  end

  assign ctl_out = ctl_out_r;
  assign quot    = quot_r;

endmodule

>>> rtl/tbs_box.sv
module tbs_box #(
  parameter int COORD_BITS = tbs_pkg::COORD_BITS_DEF,
  parameter int LAT        = 4
) (
  input  logic                               clk,
  input  logic                               en,
  input  tbs_pkg::tbs_axis_t                 iss_axis,
  input  logic                               iss_last,
  input  logic [4*COORD_BITS-1:0]            iss_crd,
  input  logic [tbs_pkg::TOL_BITS-1:0]       tol,
  output tbs_pkg::tbs_axis_t                 box_axis,
  output logic                               box_last,
  output logic [COORD_BITS-1:0]              box_low,
  output logic [COORD_BITS-1:0]              box_high
);
  import tbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int BW = ((CB > TOL_BITS) ? CB : TOL_BITS) + 2;

  localparam logic signed [BW-1:0] LIM_MAX = {{(BW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [BW-1:0] LIM_MIN = {{(BW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  typedef struct packed {
    tbs_axis_t     axis;
    logic          last;
    logic [CB-1:0] lo;
    logic [CB-1:0] hi;
  } side_t;

  logic signed [CB-1:0] crd [NUM_VERT];
  logic signed [CB-1:0] mn01, mn23, mx01, mx23;
  logic signed [CB-1:0] mn1_r, mx1_r;
  tbs_axis_t            axis1_r;
  logic                 last1_r;
  logic signed [BW-1:0] lo_w, hi_w;
  side_t                side_nxt;
  side_t                side_r [LAT-1];

  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      crd[k] = iss_crd[k*CB +: CB];
    end
    mn01 = (crd[1] < crd[0]) ? crd[1] : crd[0];
    mx01 = (crd[1] > crd[0]) ? crd[1] : crd[0];
    mn23 = (crd[3] < crd[2]) ? crd[3] : crd[2];
    mx23 = (crd[3] > crd[2]) ? crd[3] : crd[2];
  end

  always_comb begin
    lo_w = $signed({{(BW-CB){mn1_r[CB-1]}}, mn1_r}) - $signed({{(BW-TOL_BITS){1'b0}}, tol});
    hi_w = $signed({{(BW-CB){mx1_r[CB-1]}}, mx1_r}) + $signed({{(BW-TOL_BITS){1'b0}}, tol});
    side_nxt.axis = axis1_r;
    side_nxt.last = last1_r;
    side_nxt.lo   = (lo_w < LIM_MIN) ? LIM_MIN[CB-1:0] : lo_w[CB-1:0];
    side_nxt.hi   = (hi_w > LIM_MAX) ? LIM_MAX[CB-1:0] : hi_w[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn1_r     <= (mn23 < mn01) ? mn23 : mn01;
      mx1_r     <= (mx23 > mx01) ? mx23 : mx01;
      axis1_r   <= iss_axis;
      last1_r   <= iss_last;
      side_r[0] <= side_nxt;
      for (int k = 1; k < LAT - 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign box_axis = side_r[LAT-2].axis;
  assign box_last = side_r[LAT-2].last;
  assign box_low  = side_r[LAT-2].lo;
  assign box_high = side_r[LAT-2].hi;

endmodule

>>> rtl/tetra_barycentric_setup_core.sv
// Channel   Dir  Transaction contents (lowest bits first)
// in_       in   tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z v3_x v3_y v3_z
// out_      out  tdata: inv_first inv_second inv_third box_low box_high;
//                tuser: axis_row singular; tlast: last_row
// cfg_      in   wdata: box_tolerance, written when cfg_we is high
//
// Each input transaction yields three output rows, one per cycle while the output is not
// stalled; the row sequencer takes the next transaction while it issues the last row.
// Reset is synchronous and active low; it clears all valid bits and the tolerance.
// The pipeline advances as one; a stalled output freezes every stage and the input.
module tetra_barycentric_setup_core #(
  parameter int COORD_BITS = tbs_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]            in_tdata,   // v0_x .. v3_z
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [((5*COORD_BITS+7)/8)*8-1:0]             out_tdata,  // inv_first, inv_second,
                                                                    // inv_third, box_low, box_high
  output logic [tbs_pkg::TUSER_BITS-1:0]                out_tuser,  // axis_row, singular
  output logic                                          out_tlast,
  input  logic                                          cfg_we,
  input  logic [tbs_pkg::TOL_BITS-1:0]                  cfg_wdata
);
  import tbs_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int EW    = CB + 1;
  localparam int CW    = 2 * EW + 1;
  localparam int DW    = EW + CW + 2;
  localparam int OUT_W = ((5 * CB + 7) / 8) * 8;
  localparam int LAT   = LAT_COF + tbs_div_lat(CB);

  logic                      en;
  logic [TOL_BITS-1:0]       tol_r;

  logic                      iss_valid;
  tbs_axis_t                 iss_axis;
  logic                      iss_last;
  logic [3*EW-1:0]           iss_rr, iss_ra, iss_rb;
  logic [4*CB-1:0]           iss_crd;

  tbs_lane_ctl_t [2:0]       lane_ctl;
  logic [3*CW-1:0]           cof_mag;
  logic [DW-1:0]             det_mag;
  tbs_lane_ctl_t [2:0]       div_ctl;
  logic [CB-1:0]             quot [NUM_AXIS];

  tbs_axis_t                 box_axis;
  logic                      box_last;
  logic [CB-1:0]             box_low, box_high;

  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_data_r;
  logic [TUSER_BITS-1:0]     out_user_r;
  logic                      out_last_r;

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  tbs_seq #(.COORD_BITS(CB)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_vtx    (in_tdata[12*CB-1:0]),
    .in_ready  (in_tready),
    .iss_valid (iss_valid),
    .iss_axis  (iss_axis),
    .iss_last  (iss_last),
    .iss_rr    (iss_rr),
    .iss_ra    (iss_ra),
    .iss_rb    (iss_rb),
    .iss_crd   (iss_crd)
  );

  tbs_cof #(.COORD_BITS(CB)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .iss_valid (iss_valid),
    .iss_rr    (iss_rr),
    .iss_ra    (iss_ra),
    .iss_rb    (iss_rb),
    .lane_ctl  (lane_ctl),
    .cof_mag   (cof_mag),
    .det_mag   (det_mag)
  );

  for (genvar c = 0; c < NUM_AXIS; c++) begin : g_lane
    tbs_div #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (lane_ctl[c]),
      .cof_mag (cof_mag[c*CW +: CW]),
      .det_mag (det_mag),
      .ctl_out (div_ctl[c]),
      .quot    (quot[c])
    );
  end

  tbs_box #(.COORD_BITS(CB), .LAT(LAT)) u_box (
    .clk      (clk),
    .en       (en),
    .iss_axis (iss_axis),
    .iss_last (iss_last),
    .iss_crd  (iss_crd),
    .tol      (tol_r),
    .box_axis (box_axis),
    .box_last (box_last),
    .box_low  (box_low),
    .box_high (box_high)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_ctl[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({box_high, box_low, quot[2], quot[1], quot[0]});
      out_user_r <= {div_ctl[0].sing, box_axis};
      out_last_r <= box_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[3*CB-1:0] == '0)
    else $error("singular row carries nonzero entries");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tuser[1:0] == AXIS_Z))
    else $error("tlast not aligned with the z row");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[4*CB-1:3*CB]) <= $signed(out_tdata[5*CB-1:4*CB]))
    else $error("box bounds out of order");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while the pipeline is stalled");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl[1].valid == div_ctl[0].valid && div_ctl[2].valid == div_ctl[0].valid)
    else $error("divider lanes out of step");

endmodule
